// File: rtl/hcb_pkg.sv
// ----------------------------------------------------------------------------
// Huffman code builder package
// Shared constants, codes, memory word layouts and a helper function.
// ----------------------------------------------------------------------------
package hcb_pkg;

  // Table and field sizes.
  localparam int unsigned NUM_SYMBOLS = 256;
  localparam int unsigned SYM_W       = 8;
  localparam int unsigned WEIGHT_W    = 17;
  localparam int unsigned CODE_BITS   = 32;
  localparam int unsigned CODE_IDX_W  = $clog2(CODE_BITS);
  localparam int unsigned LEN_W       = 8;
  localparam int unsigned CNT_W       = 9;
  localparam int unsigned ONE_Q16     = 65536;

  // Operation codes carried by each request item.
  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_BUILD = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUERY,
    ST_INIT,
    ST_SCAN,
    ST_SYM,
    ST_SHIFT
  } state_t;

  // One entry of the symbol table.
  typedef struct packed {
    logic [WEIGHT_W-1:0]  weight;
    logic [SYM_W-1:0]     node_id;
    logic [CODE_BITS-1:0] code;
    logic [LEN_W-1:0]     len;
  } sym_entry_t;

  // Write request to the symbol table.
  typedef struct packed {
    logic             en;
    logic [SYM_W-1:0] addr;
    sym_entry_t       data;
  } sym_wr_t;

  // Write request to the node weight table.
  typedef struct packed {
    logic                en;
    logic [SYM_W-1:0]    addr;
    logic [WEIGHT_W-1:0] data;
  } node_wr_t;

  // Prepend one bit to a symbol's code; the bit lands above those already held.
  function automatic sym_entry_t push_bit(sym_entry_t e, logic bit_val);
    sym_entry_t r;
    r = e;
    if ((e.len < LEN_W'(CODE_BITS)) && bit_val) begin
      r.code[e.len[CODE_IDX_W-1:0]] = 1'b1;
    end
    if (e.len != {LEN_W{1'b1}}) begin
      r.len = e.len + LEN_W'(1);
    end
    return r;
  endfunction

endpackage

// File: rtl/hcb_req_if.sv
// ----------------------------------------------------------------------------
// Huffman code builder request channel
// Valid/ready channel carrying one request item: mode, symbol and weight.
// ----------------------------------------------------------------------------
interface hcb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  symbol;
  logic [16:0] weight;

  modport source (output valid, output mode, output symbol, output weight, input ready);
  modport sink (input valid, input mode, input symbol, input weight, output ready);
endinterface

// File: rtl/hcb_rsp_if.sv
// ----------------------------------------------------------------------------
// Huffman code builder response channel
// Valid/ready channel carrying one response item per request item.
// ----------------------------------------------------------------------------
interface hcb_rsp_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [31:0] code_bits;
  logic [7:0]  code_length;
  logic        code_overflow;

  modport source (output valid, output accepted, output code_bits, output code_length,
                  output code_overflow, input ready);
  modport sink (input valid, input accepted, input code_bits, input code_length,
                input code_overflow, output ready);
endinterface

// File: rtl/hcb_sym_mem.sv
// ----------------------------------------------------------------------------
// Huffman code builder symbol table
// One write port and one registered read port over the per-symbol entries.
// ----------------------------------------------------------------------------
module hcb_sym_mem (
  input  logic                           clk,
  input  hcb_pkg::sym_wr_t               wr,
  input  logic [hcb_pkg::SYM_W-1:0]      rd_addr,
  output hcb_pkg::sym_entry_t            rd_data
);

  hcb_pkg::sym_entry_t mem [hcb_pkg::NUM_SYMBOLS];

  // Write first in program order; the read returns the old contents.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/hcb_node_mem.sv
// ----------------------------------------------------------------------------
// Huffman code builder node weight table
// One write port and one registered read port over the live node weights.
// ----------------------------------------------------------------------------
module hcb_node_mem (
  input  logic                           clk,
  input  hcb_pkg::node_wr_t              wr,
  input  logic [hcb_pkg::SYM_W-1:0]      rd_addr,
  output logic [hcb_pkg::WEIGHT_W-1:0]   rd_data
);

  logic [hcb_pkg::WEIGHT_W-1:0] mem [hcb_pkg::NUM_SYMBOLS];

  // Single write port, registered read.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/huffman_code_builder_unit.sv
// ----------------------------------------------------------------------------
// Huffman code builder
// Stores weighted byte symbols, builds Huffman codes and answers code queries.
// ----------------------------------------------------------------------------
// Add and clear items are answered from the idle state; a query also passes
// through the query state, which takes the registered read of the symbol
// table. A build walks the symbol table once to number the stored symbols as
// live nodes, then for each of the N-1 merges over N loaded symbols it scans
// the live node weights, rewrites every stored symbol entry and shifts the
// node weights above the merged pair down; the symbol table pass always covers
// all entries, whatever the number of live nodes. One item is in work at a
// time, and a finished response that has not yet been taken holds off the next item.
module huffman_code_builder_unit (
  input logic        clk,
  input logic        rst,
  hcb_req_if.sink    req,
  hcb_rsp_if.source  rsp
);

  localparam logic [hcb_pkg::CNT_W-1:0] NumSym = hcb_pkg::CNT_W'(hcb_pkg::NUM_SYMBOLS);

  hcb_pkg::state_t state, state_next;

  logic [hcb_pkg::CNT_W-1:0]    idx, idx_next;
  logic [hcb_pkg::CNT_W-1:0]    rd_idx;
  logic                         pend, pend_next;
  logic [hcb_pkg::CNT_W-1:0]    live, live_next;
  logic [hcb_pkg::CNT_W-1:0]    limit;
  logic                         issue, pass_done;
  logic [hcb_pkg::WEIGHT_W-1:0] m1, m1_next, m2, m2_next;
  logic [hcb_pkg::SYM_W-1:0]    i1, i1_next, i2, i2_next;
  logic                         have1, have1_next, have2, have2_next;
  logic [hcb_pkg::WEIGHT_W-1:0] total, total_next;
  logic                         q_hit, q_hit_next;
  logic [hcb_pkg::NUM_SYMBOLS-1:0] present;
  logic                         set_present, clear_present;
  logic [hcb_pkg::SYM_W-1:0]    lo, hi;
  logic                         accept, add_ok;

  hcb_pkg::sym_wr_t             sym_wr;
  hcb_pkg::node_wr_t            node_wr;
  logic [hcb_pkg::SYM_W-1:0]    sym_rd_addr;
  hcb_pkg::sym_entry_t          sym_rd_data;
  hcb_pkg::sym_entry_t          upd;
  logic [hcb_pkg::WEIGHT_W-1:0] node_rd_data;

  logic                         load_rsp;
  logic                         load_acc;
  logic [hcb_pkg::CODE_BITS-1:0] load_code;
  logic [hcb_pkg::LEN_W-1:0]    load_len;
  logic                         load_ovf;

  // Memories.
  hcb_sym_mem u_sym_mem (
    .clk     (clk),
    .wr      (sym_wr),
    .rd_addr (sym_rd_addr),
    .rd_data (sym_rd_data)
  );

  hcb_node_mem u_node_mem (
    .clk     (clk),
    .wr      (node_wr),
    .rd_addr (idx[hcb_pkg::SYM_W-1:0]),
    .rd_data (node_rd_data)
  );

  // Handshake and address selection.
  assign req.ready   = (state == hcb_pkg::ST_IDLE) && (!rsp.valid || rsp.ready);
  assign accept      = req.valid && req.ready;
  assign sym_rd_addr = (state == hcb_pkg::ST_IDLE) ? req.symbol : idx[hcb_pkg::SYM_W-1:0];

  // An add needs a new symbol and must keep the total at or below one.
  assign add_ok = ({1'b0, req.symbol} < NumSym) && !present[req.symbol] &&
                  (({1'b0, total} + {1'b0, req.weight}) <= 18'(hcb_pkg::ONE_Q16));

  // The merged pair, ordered by node id.
  assign lo = (i1 < i2) ? i1 : i2;
  assign hi = (i1 < i2) ? i2 : i1;

  // Length of the current table pass.
  always_comb begin
    case (state)
      hcb_pkg::ST_INIT, hcb_pkg::ST_SYM:   limit = NumSym;
      hcb_pkg::ST_SCAN, hcb_pkg::ST_SHIFT: limit = live;
      default:                             limit = '0;
    endcase
  end

  assign issue     = idx < limit;
  assign pass_done = !issue && !pend;

  // Next state and datapath control.
  always_comb begin
    state_next    = state;
    idx_next      = issue ? idx + hcb_pkg::CNT_W'(1) : idx;
    pend_next     = issue;
    live_next     = live;
    m1_next       = m1;
    m2_next       = m2;
    i1_next       = i1;
    i2_next       = i2;
    have1_next    = have1;
    have2_next    = have2;
    total_next    = total;
    q_hit_next    = q_hit;
    set_present   = 1'b0;
    clear_present = 1'b0;
    sym_wr        = '0;
    node_wr       = '0;
    upd           = sym_rd_data;
    load_rsp      = 1'b0;
    load_acc      = 1'b1;
    load_code     = '0;
    load_len      = '0;
    load_ovf      = 1'b0;

    case (state)
      hcb_pkg::ST_IDLE: begin
        if (accept) begin
          case (hcb_pkg::mode_t'(req.mode))
            hcb_pkg::MODE_ADD: begin
              load_rsp = 1'b1;
              load_acc = add_ok;
              if (add_ok) begin
                sym_wr.en          = 1'b1;
                sym_wr.addr        = req.symbol;
                sym_wr.data        = '0;
                sym_wr.data.weight = req.weight;
                total_next         = total + req.weight;
                set_present        = 1'b1;
              end
            end
            hcb_pkg::MODE_BUILD: begin
              state_next = hcb_pkg::ST_INIT;
              idx_next   = '0;
              live_next  = '0;
            end
            hcb_pkg::MODE_QUERY: begin
              state_next = hcb_pkg::ST_QUERY;
              q_hit_next = ({1'b0, req.symbol} < NumSym) && present[req.symbol];
            end
            hcb_pkg::MODE_CLEAR: begin
              load_rsp      = 1'b1;
              clear_present = 1'b1;
              total_next    = '0;
            end
            default: begin
              load_rsp = 1'b1;
            end
          endcase
        end
      end

      hcb_pkg::ST_QUERY: begin
        // The table read issued with the item has landed.
        load_rsp   = 1'b1;
        state_next = hcb_pkg::ST_IDLE;
        if (q_hit) begin
          load_code = sym_rd_data.code;
          load_len  = sym_rd_data.len;
          load_ovf  = sym_rd_data.len > hcb_pkg::LEN_W'(hcb_pkg::CODE_BITS);
        end
      end

      hcb_pkg::ST_INIT: begin
        // Number the stored symbols as leaf nodes and empty their codes.
        if (pend && present[rd_idx[hcb_pkg::SYM_W-1:0]]) begin
          sym_wr.en           = 1'b1;
          sym_wr.addr         = rd_idx[hcb_pkg::SYM_W-1:0];
          sym_wr.data         = '0;
          sym_wr.data.weight  = sym_rd_data.weight;
          sym_wr.data.node_id = live[hcb_pkg::SYM_W-1:0];
          node_wr.en          = 1'b1;
          node_wr.addr        = live[hcb_pkg::SYM_W-1:0];
          node_wr.data        = sym_rd_data.weight;
          live_next           = live + hcb_pkg::CNT_W'(1);
        end
        if (pass_done) begin
          idx_next   = '0;
          have1_next = 1'b0;
          have2_next = 1'b0;
          if (live > hcb_pkg::CNT_W'(1)) begin
            state_next = hcb_pkg::ST_SCAN;
          end else begin
            state_next = hcb_pkg::ST_IDLE;
            load_rsp   = 1'b1;
          end
        end
      end

      hcb_pkg::ST_SCAN: begin
        // Track the two lightest nodes; ties go to the higher id.
        if (pend) begin
          if (!have1 || (node_rd_data <= m1)) begin
            m2_next    = m1;
            i2_next    = i1;
            have2_next = have1;
            m1_next    = node_rd_data;
            i1_next    = rd_idx[hcb_pkg::SYM_W-1:0];
            have1_next = 1'b1;
          end else if (!have2 || (node_rd_data <= m2)) begin
            m2_next    = node_rd_data;
            i2_next    = rd_idx[hcb_pkg::SYM_W-1:0];
            have2_next = 1'b1;
          end
        end
        if (pass_done) begin
          state_next = hcb_pkg::ST_SYM;
          idx_next   = '0;
        end
      end

      hcb_pkg::ST_SYM: begin
        // Extend the codes of both merged nodes and renumber the nodes above.
        if (pend && present[rd_idx[hcb_pkg::SYM_W-1:0]]) begin
          if (sym_rd_data.node_id == lo) begin
            upd = hcb_pkg::push_bit(sym_rd_data, 1'b1);
          end else if (sym_rd_data.node_id == hi) begin
            upd         = hcb_pkg::push_bit(sym_rd_data, 1'b0);
            upd.node_id = lo;
          end else if (sym_rd_data.node_id > hi) begin
            upd.node_id = sym_rd_data.node_id - hcb_pkg::SYM_W'(1);
          end
          sym_wr.en   = 1'b1;
          sym_wr.addr = rd_idx[hcb_pkg::SYM_W-1:0];
          sym_wr.data = upd;
        end
        if (pass_done) begin
          node_wr.en   = 1'b1;
          node_wr.addr = lo;
          node_wr.data = m1 + m2;
          state_next   = hcb_pkg::ST_SHIFT;
          idx_next     = {1'b0, hi} + hcb_pkg::CNT_W'(1);
        end
      end

      hcb_pkg::ST_SHIFT: begin
        // Close the gap left by the folded node.
        if (pend) begin
          node_wr.en   = 1'b1;
          node_wr.addr = rd_idx[hcb_pkg::SYM_W-1:0] - hcb_pkg::SYM_W'(1);
          node_wr.data = node_rd_data;
        end
        if (pass_done) begin
          live_next  = live - hcb_pkg::CNT_W'(1);
          idx_next   = '0;
          have1_next = 1'b0;
          have2_next = 1'b0;
          if (live > hcb_pkg::CNT_W'(2)) begin
            state_next = hcb_pkg::ST_SCAN;
          end else begin
            state_next = hcb_pkg::ST_IDLE;
            load_rsp   = 1'b1;
          end
        end
      end

      default: begin
        state_next = hcb_pkg::ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hcb_pkg::ST_IDLE;
      pend  <= 1'b0;
      total <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      total <= total_next;
      idx   <= idx_next;
    end
  end

  // Pass counters and the two-smallest tracker.
  always_ff @(posedge clk) begin
    rd_idx <= idx;
    live   <= live_next;
    m1     <= m1_next;
    m2     <= m2_next;
    i1     <= i1_next;
    i2     <= i2_next;
    have1  <= have1_next;
    have2  <= have2_next;
    q_hit  <= q_hit_next;
  end

  // Presence flags, one per symbol.
  always_ff @(posedge clk) begin
    if (rst || clear_present) begin
      present <= '0;
    end else if (set_present) begin
      present[req.symbol] <= 1'b1;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_rsp) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.accepted      <= load_acc;
      rsp.code_bits     <= load_code;
      rsp.code_length   <= load_len;
      rsp.code_overflow <= load_ovf;
    end
  end

endmodule

// File: tb/huffman_code_builder_unit_test.sv
// ----------------------------------------------------------------------------
// Huffman code builder unit testbench
// Sends add, build, query and clear items through the request channel with
// random gaps, predicts every response with a software copy of the symbol
// table and code builder, and checks each response item field by field.
// ----------------------------------------------------------------------------
module huffman_code_builder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_WAIT  = 300;
  localparam int unsigned CODE_LIMIT  = 32;
  localparam int unsigned RANDOM_ITEMS = 1150;

  typedef struct {
    logic        accepted;
    logic [31:0] code_bits;
    logic [7:0]  code_length;
    logic        code_overflow;
  } code_rsp_t;

  logic clk;
  logic rst;

  hcb_req_if req ();
  hcb_rsp_if rsp ();

  huffman_code_builder_unit uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Software copy of the symbol table.
  bit          sym_live [hcb_pkg::NUM_SYMBOLS];
  int unsigned sym_wt   [hcb_pkg::NUM_SYMBOLS];
  int unsigned sym_node [hcb_pkg::NUM_SYMBOLS];
  int unsigned node_wt  [hcb_pkg::NUM_SYMBOLS];
  bit [31:0]   sym_bits [hcb_pkg::NUM_SYMBOLS];
  int unsigned sym_len  [hcb_pkg::NUM_SYMBOLS];
  int unsigned wt_total;

  code_rsp_t   pending_rsp [$];
  int          mismatches;
  int unsigned items_sent;
  int unsigned hold_cycles;
  bit          quiet;

  // Clock generation.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Empty the table and codes.
  function automatic void table_clear();
    for (int s = 0; s < hcb_pkg::NUM_SYMBOLS; s++) begin
      sym_live[s] = 1'b0;
      sym_wt[s]   = 0;
      sym_node[s] = 0;
      node_wt[s]  = 0;
      sym_bits[s] = '0;
      sym_len[s]  = 0;
    end
    wt_total = 0;
  endfunction

  // Prepend one code bit to a symbol; only the first CODE_LIMIT are stored.
  function automatic void code_prepend(int s, bit b);
    if (sym_len[s] < CODE_LIMIT && b) sym_bits[s][sym_len[s]] = 1'b1;
    if (sym_len[s] < 255) sym_len[s]++;
  endfunction

  // Merge the two lightest nodes until one remains.
  function automatic void codes_build();
    int unsigned live;
    int unsigned a, b, lo, hi;
    bit have;
    live = 0;
    for (int s = 0; s < hcb_pkg::NUM_SYMBOLS; s++) begin
      sym_bits[s] = '0;
      sym_len[s]  = 0;
      if (sym_live[s]) begin
        sym_node[s]   = live;
        node_wt[live] = sym_wt[s];
        live++;
      end
    end
    while (live > 1) begin
      a = 0;
      b = 0;
      have = 1'b0;
      for (int i = 1; i < live; i++)
        if (node_wt[i] <= node_wt[a]) a = i;
      for (int i = 0; i < live; i++) begin
        if (i != a && (!have || node_wt[i] <= node_wt[b])) begin
          b = i;
          have = 1'b1;
        end
      end
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      for (int s = 0; s < hcb_pkg::NUM_SYMBOLS; s++) begin
        if (sym_live[s]) begin
          if (sym_node[s] == lo) code_prepend(s, 1'b1);
          else if (sym_node[s] == hi) begin
            code_prepend(s, 1'b0);
            sym_node[s] = lo;
          end else if (sym_node[s] > hi) sym_node[s]--;
        end
      end
      node_wt[lo] += node_wt[hi];
      for (int i = hi; i + 1 < live; i++) node_wt[i] = node_wt[i + 1];
      live--;
    end
  endfunction

  // Apply one request to the software table and return the response.
  function automatic code_rsp_t code_predict(hcb_pkg::mode_t m, logic [7:0] s,
                                             logic [16:0] w);
    code_rsp_t r;
    r.accepted      = 1'b1;
    r.code_bits     = '0;
    r.code_length   = '0;
    r.code_overflow = 1'b0;
    case (m)
      hcb_pkg::MODE_ADD: begin
        if (sym_live[s] || wt_total + w > hcb_pkg::ONE_Q16) r.accepted = 1'b0;
        else begin
          sym_live[s] = 1'b1;
          sym_wt[s]   = w;
          sym_bits[s] = '0;
          sym_len[s]  = 0;
          wt_total   += w;
        end
      end
      hcb_pkg::MODE_BUILD: codes_build();
      hcb_pkg::MODE_QUERY: begin
        if (sym_live[s]) begin
          r.code_bits     = sym_bits[s];
          r.code_length   = sym_len[s][7:0];
          r.code_overflow = (sym_len[s] > CODE_LIMIT);
        end
      end
      default: table_clear();
    endcase
    return r;
  endfunction

  // Send one request item after a random gap and queue its predicted response.
  task automatic send_item(hcb_pkg::mode_t m, logic [7:0] s, logic [16:0] w);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid  <= 1'b1;
    req.mode   <= m;
    req.symbol <= s;
    req.weight <= w;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_rsp.insert(pending_rsp.size(), code_predict(m, s, w));
    items_sent++;
  endtask

  // Lower valid and wait until every response has come back.
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // Response side: random stalls, plus an occasional long hold-off.
  initial begin
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      int unsigned stall;
      if (hold_cycles > 0) begin
        rsp.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      stall = quiet ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
    end
  end

  // Compare every response item with the oldest prediction.
  always @(posedge clk) begin
    code_rsp_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response item acc=%0b bits=%h len=%0d ovf=%0b", $realtime,
                 rsp.accepted, rsp.code_bits, rsp.code_length, rsp.code_overflow);
        mismatches++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp.accepted !== e.accepted) begin
          $display("%0t: accepted expected %0b actual %0b", $realtime, e.accepted,
                   rsp.accepted);
          mismatches++;
        end
        if (rsp.code_bits !== e.code_bits) begin
          $display("%0t: code_bits expected %h actual %h", $realtime, e.code_bits,
                   rsp.code_bits);
          mismatches++;
        end
        if (rsp.code_length !== e.code_length) begin
          $display("%0t: code_length expected %0d actual %0d", $realtime, e.code_length,
                   rsp.code_length);
          mismatches++;
        end
        if (rsp.code_overflow !== e.code_overflow) begin
          $display("%0t: code_overflow expected %0b actual %0b", $realtime, e.code_overflow,
                   rsp.code_overflow);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles in which no item moves on either channel.
  initial begin
    int unsigned idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Extremes of the fields, rejections and the small-table cases.
  task automatic test_directed();
    send_item(hcb_pkg::MODE_QUERY, 8'd7, 17'd0);
    send_item(hcb_pkg::MODE_BUILD, 8'd0, 17'd0);
    send_item(hcb_pkg::MODE_ADD, 8'd255, 17'd65536);
    send_item(hcb_pkg::MODE_ADD, 8'd0, 17'd1);
    send_item(hcb_pkg::MODE_ADD, 8'd255, 17'd0);
    send_item(hcb_pkg::MODE_QUERY, 8'd255, 17'd0);
    send_item(hcb_pkg::MODE_BUILD, 8'd0, 17'd0);
    send_item(hcb_pkg::MODE_QUERY, 8'd255, 17'd131071);
    send_item(hcb_pkg::MODE_CLEAR, 8'd255, 17'd131071);
    send_item(hcb_pkg::MODE_QUERY, 8'd255, 17'd0);
    send_item(hcb_pkg::MODE_ADD, 8'd1, 17'd131071);
    send_item(hcb_pkg::MODE_ADD, 8'd0, 17'd0);
    send_item(hcb_pkg::MODE_ADD, 8'd170, 17'd21845);
    send_item(hcb_pkg::MODE_ADD, 8'd85, 17'd43690);
    send_item(hcb_pkg::MODE_ADD, 8'd3, 17'd1);
    send_item(hcb_pkg::MODE_ADD, 8'd4, 17'd0);
    send_item(hcb_pkg::MODE_QUERY, 8'd170, 17'd0);
    send_item(hcb_pkg::MODE_BUILD, 8'd0, 17'd0);
    send_item(hcb_pkg::MODE_QUERY, 8'd0, 17'd0);
    send_item(hcb_pkg::MODE_QUERY, 8'd170, 17'd0);
    send_item(hcb_pkg::MODE_QUERY, 8'd85, 17'd0);
    send_item(hcb_pkg::MODE_QUERY, 8'd4, 17'd0);
    send_item(hcb_pkg::MODE_QUERY, 8'd9, 17'd0);
    drain();
  endtask

  // Zero weights give a chain of merges and codes longer than 32 bits.
  task automatic test_long_code();
    send_item(hcb_pkg::MODE_CLEAR, 8'd0, 17'd0);
    for (int s = 0; s < 40; s++) send_item(hcb_pkg::MODE_ADD, 8'(s * 3), 17'd0);
    send_item(hcb_pkg::MODE_BUILD, 8'd0, 17'd0);
    for (int s = 0; s < 40; s += 3) send_item(hcb_pkg::MODE_QUERY, 8'(s * 3), 17'd0);
    send_item(hcb_pkg::MODE_QUERY, 8'd117, 17'd0);
    send_item(hcb_pkg::MODE_QUERY, 8'd114, 17'd0);
    drain();
  endtask

  // Every symbol loaded, filling the total exactly.
  task automatic test_full_table();
    send_item(hcb_pkg::MODE_CLEAR, 8'd0, 17'd0);
    for (int s = 0; s < hcb_pkg::NUM_SYMBOLS; s++)
      send_item(hcb_pkg::MODE_ADD, 8'(s),
                17'(((s % 4) == 0) ? 128 : 256 + ((s % 4) == 1 ? 128 : 0)));
    send_item(hcb_pkg::MODE_BUILD, 8'd0, 17'd0);
    for (int i = 0; i < 16; i++)
      send_item(hcb_pkg::MODE_QUERY, 8'($urandom_range(0, 255)), 17'd0);
    drain();
  endtask

  // Hold the response side off while requests keep coming.
  task automatic test_back_pressure();
    hold_cycles = 400;
    send_item(hcb_pkg::MODE_CLEAR, 8'd0, 17'd0);
    for (int i = 0; i < 6; i++)
      send_item(hcb_pkg::MODE_ADD, 8'(i * 40), 17'(1000 * (i + 1)));
    send_item(hcb_pkg::MODE_BUILD, 8'd0, 17'd0);
    for (int i = 0; i < 8; i++) send_item(hcb_pkg::MODE_QUERY, 8'(i * 40), 17'd0);
    drain();
  endtask

  // Random sessions: fill a small table, build, then query.
  task automatic test_random();
    int unsigned n, budget;
    logic [16:0] w;
    logic [7:0]  s;
    while (items_sent < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 5) == 0);
      send_item(hcb_pkg::MODE_CLEAR, 8'($urandom), 17'($urandom));
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(2, 12);
      for (int i = 0; i < n; i++) begin
        budget = hcb_pkg::ONE_Q16 - wt_total;
        case ($urandom_range(0, 9))
          0: w = 17'($urandom);
          1: w = 17'(budget);
          2: w = 17'd0;
          default: w = 17'($urandom_range(0, (budget / 4 > 0) ? budget / 4 : 1));
        endcase
        s = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        send_item(hcb_pkg::MODE_ADD, s, w);
      end
      if ($urandom_range(0, 3) == 0)
        send_item(hcb_pkg::MODE_QUERY, 8'($urandom), 17'($urandom));
      send_item(hcb_pkg::MODE_BUILD, 8'($urandom), 17'($urandom));
      for (int i = 0; i < n + 4; i++) begin
        s = 8'($urandom);
        for (int k = 0; k < 4 && !sym_live[s]; k++) s = 8'($urandom);
        send_item(hcb_pkg::MODE_QUERY, s, 17'($urandom));
      end
      if ($urandom_range(0, 4) == 0) begin
        send_item(hcb_pkg::MODE_ADD, 8'($urandom), 17'($urandom_range(0, 64)));
        send_item(hcb_pkg::MODE_QUERY, 8'($urandom), 17'd0);
        send_item(hcb_pkg::MODE_BUILD, 8'd0, 17'd0);
      end
    end
    quiet = 1'b0;
  endtask

  // Test sequence.
  initial begin
    mismatches  = 0;
    items_sent  = 0;
    hold_cycles = 0;
    quiet       = 1'b0;
    table_clear();
    rst        <= 1'b1;
    req.valid  <= 1'b0;
    req.mode   <= hcb_pkg::MODE_ADD;
    req.symbol <= '0;
    req.weight <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_long_code();
    test_back_pressure();
    test_full_table();
    test_random();
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
